>>> rtl/smpm_pkg.sv
// ----------------------------------------------------------------------------
// smpm_pkg
// Shared types and constants for the tick-paced SPI mode-0 master.
// ----------------------------------------------------------------------------
package smpm_pkg;

    localparam int TX_W      = 8;
    localparam int BITCNT_W  = 4;
    localparam int TICK_W    = 7;
    localparam int DUR_W     = 8;

    // Request kinds carried on the input side.
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    localparam logic [DUR_W-1:0] SCK_DURATION_RESET = '0;

    // Register index of the clock duration setting.
    localparam logic REG_SCK_DURATION = 1'b0;

    // One result item.
    typedef struct packed {
        logic [TX_W-1:0] rx_byte;
        logic            byte_done;
        logic            busy_res;
        logic            mosi;
        logic            sck;
    } result_t;

endpackage

>>> rtl/smpm_core.sv
// ----------------------------------------------------------------------------
// smpm_core
// Transfer state and the per-request step: load, half-period count, SCK edge,
// MISO sampling and MOSI update.
// ----------------------------------------------------------------------------
module smpm_core
    import smpm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step_en,
    input  logic             req_type,
    input  logic [TX_W-1:0]  tx_byte,
    input  logic             miso,
    input  logic [DUR_W-1:0] sck_duration,
    output result_t          result
);

    logic [TX_W-1:0]     shift_reg, shift_next;
    logic [BITCNT_W-1:0] bits_left_reg, bits_left_next;
    logic [TICK_W-1:0]   tick_count_reg, tick_count_next;
    logic                clock_high_reg, clock_high_next;
    logic                active_reg, active_next;
    logic                mosi_reg, mosi_next;

    logic [DUR_W:0]      dur_plus;
    logic [TICK_W-1:0]   half_raw;
    logic [TICK_W-1:0]   half_period;
    logic [TICK_W:0]     tick_inc;
    logic [BITCNT_W-1:0] bits_dec;
    logic                done;
    logic [TX_W-1:0]     rx;

    // half period = (d+1)/4 + (d+1)/16, short values forced to one tick
    assign dur_plus    = {1'b0, sck_duration} + 9'd1;
    assign half_raw    = TICK_W'(dur_plus[DUR_W:2]) + TICK_W'(dur_plus[DUR_W:4]);
    assign half_period = (half_raw < TICK_W'(10)) ? TICK_W'(1) : half_raw;

    assign tick_inc = {1'b0, tick_count_reg} + (TICK_W+1)'(1);
    assign bits_dec = bits_left_reg - BITCNT_W'(1);

    always_comb
    begin
        shift_next      = shift_reg;
        bits_left_next  = bits_left_reg;
        tick_count_next = tick_count_reg;
        clock_high_next = clock_high_reg;
        active_next     = active_reg;
        mosi_next       = mosi_reg;
        done            = 1'b0;
        rx              = '0;
        if (req_type == REQ_LOAD)
        begin
            if (!active_reg)
            begin
                active_next     = 1'b1;
                shift_next      = tx_byte;
                bits_left_next  = BITCNT_W'(TX_W);
                tick_count_next = '0;
                clock_high_next = 1'b0;
                mosi_next       = tx_byte[TX_W-1];
            end
        end
        else if (active_reg)
        begin
            if (tick_inc >= {1'b0, half_period})
            begin
                tick_count_next = '0;
                if (!clock_high_reg)
                begin
                    // rising edge: sample MISO
                    clock_high_next = 1'b1;
                    shift_next      = {shift_reg[TX_W-2:0], miso};
                end
                else
                begin
                    // falling edge: next bit or end of byte
                    clock_high_next = 1'b0;
                    bits_left_next  = bits_dec;
                    if (bits_dec == '0)
                    begin
                        active_next = 1'b0;
                        done        = 1'b1;
                        rx          = shift_reg;
                    end
                    else
                    begin
                        mosi_next = shift_reg[TX_W-1];
                    end
                end
            end
            else
            begin
                tick_count_next = tick_inc[TICK_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg      <= '0;
            bits_left_reg  <= '0;
            tick_count_reg <= '0;
            clock_high_reg <= 1'b0;
            active_reg     <= 1'b0;
            mosi_reg       <= 1'b0;
        end
        else if (step_en)
        begin
            shift_reg      <= shift_next;
            bits_left_reg  <= bits_left_next;
            tick_count_reg <= tick_count_next;
            clock_high_reg <= clock_high_next;
            active_reg     <= active_next;
            mosi_reg       <= mosi_next;
        end
    end

    always_comb
    begin
        result.sck       = clock_high_next;
        result.mosi      = mosi_next;
        result.busy_res  = active_next;
        result.byte_done = done;
        result.rx_byte   = rx;
    end

endmodule

>>> rtl/spi_mode0_tick_paced_master.sv
// ----------------------------------------------------------------------------
// spi_mode0_tick_paced_master
// SPI mode-0 master (SCK idles low, MSB first) paced by tick requests.
//
//  channel   dir  handshake          payload
//  s_axis    in   tvalid/tready      tuser: req_type; tdata: tx_byte, miso
//  m_axis    out  tvalid/tready      tdata: sck, mosi, busy_res, byte_done, rx_byte
//  apb       in   psel/penable       sck_duration at address 0
//
// Each request passes once through the step logic; one request per cycle is
// sustained while the result side accepts. A request is held in the input
// register, then the step updates the transfer state and fills the result
// register. The result register parts the two sides: a new request can enter
// an empty input register while the finished result waits. Reset is
// asynchronous, active low, and clears all control and transfer state.
// ----------------------------------------------------------------------------
module spi_mode0_tick_paced_master
    import smpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [7:0] tx_byte, [8] miso, [15:9] zero
    input  logic        s_tuser,   // [0] req_type
    // results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] sck, [1] mosi, [2] busy_res,
                                   // [3] byte_done, [11:4] rx_byte, [15:12] zero
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [DUR_W-1:0] sck_duration_reg;

    logic             in_valid_reg;
    logic             in_req_reg;
    logic [TX_W-1:0]  in_tx_reg;
    logic             in_miso_reg;

    logic             out_valid_reg;
    result_t          out_reg;
    result_t          step_result;

    logic             out_free;
    logic             step_en;
    logic             in_take;
    logic             cfg_wr;

    // ---- configuration port ----
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_SCK_DURATION);
    assign prdata = (paddr[2] == REG_SCK_DURATION) ? {24'd0, sck_duration_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sck_duration_reg <= SCK_DURATION_RESET;
        else if (cfg_wr)
            sck_duration_reg <= pwdata[DUR_W-1:0];
    end

    // ---- flow control ----
    // Advance the held request whenever the result register is empty or drains.
    assign out_free = !out_valid_reg || m_tready;
    assign step_en  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || out_free;
    assign in_take  = s_tvalid && s_tready;

    // ---- input register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_req_reg  <= s_tuser;
            in_tx_reg   <= s_tdata[TX_W-1:0];
            in_miso_reg <= s_tdata[TX_W];
        end
    end

    // ---- step logic and transfer state ----
    smpm_core u_core (
        .clk          (clk),
        .rst_n        (rst_n),
        .step_en      (step_en),
        .req_type     (in_req_reg),
        .tx_byte      (in_tx_reg),
        .miso         (in_miso_reg),
        .sck_duration (sck_duration_reg),
        .result       (step_result)
    );

    // ---- result register ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_free)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            out_reg <= step_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, out_reg.rx_byte, out_reg.byte_done, out_reg.busy_res,
                       out_reg.mosi, out_reg.sck};

`ifndef SYNTH
    // Input stalls only behind a held request and a blocked result.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a blocked result");

    // A completed byte leaves the bus idle with SCK low.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.byte_done) |-> (!out_reg.busy_res && !out_reg.sck))
        else $error("byte completion while still busy or SCK high");

    // A taken request always yields a result on the next edge that has room.
    a_step_fills: assert property (@(posedge clk) disable iff (!rst_n)
        step_en |=> out_valid_reg)
        else $error("stepped request produced no result");
`endif

endmodule
